### sv/tcc_pkg.sv
// Shared types, opcodes and a helper function for the four-channel timer/counter.
// No dependencies; every other file imports this package.
package tcc_pkg;

	// Highest channel count the design supports
	localparam int MAX_CH = 8;

	typedef enum logic [3:0] {
		OP_TICK        = 4'd0,
		OP_START       = 4'd1,
		OP_STOP        = 4'd2,
		OP_COUNT       = 4'd3,
		OP_CLEAR       = 4'd4,
		OP_CAPTURE     = 4'd5,
		OP_EVENT_WR    = 4'd6,
		OP_INTEN_SET   = 4'd7,
		OP_INTEN_CLR   = 4'd8,
		OP_CC_WR       = 4'd9,
		OP_CC_RD       = 4'd10,
		OP_INTEN_RD    = 4'd11
	} op_t;

	typedef enum logic [1:0] {
		CFG_COUNTER_MODE = 2'd0,
		CFG_BIT_MODE     = 2'd1,
		CFG_PRESCALE     = 2'd2,
		CFG_SHORT_MASK   = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BM_16 = 2'd0,
		BM_8  = 2'd1,
		BM_24 = 2'd2,
		BM_32 = 2'd3
	} bit_mode_t;

	typedef struct packed {
		logic        counter_mode;
		logic [1:0]  bit_mode;
		logic [3:0]  prescale_shift;
		logic [11:0] short_mask;
	} cfg_t;

	typedef struct packed {
		logic [31:0] write_value;
		logic [1:0]  channel;
		logic [3:0]  opcode;
	} item_t;

	typedef struct packed {
		logic        irq;
		logic [3:0]  event_flags;
		logic [31:0] counter_value;
		logic [31:0] read_data;
	} result_t;

	// Count wrap mask for the selected width
	function automatic logic [31:0] width_mask(input logic [1:0] mode);
		logic [31:0] m;
		unique case (bit_mode_t'(mode))
			BM_16:   m = 32'h0000_FFFF;
			BM_8:    m = 32'h0000_00FF;
			BM_24:   m = 32'h00FF_FFFF;
			BM_32:   m = 32'hFFFF_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

### sv/timer_counter_compare_capture.sv
// Top level of the timer/counter: stream ports, configuration registers,
// input register and result register around tcc_core. Depends on tcc_pkg and tcc_core.

// The block takes one item per cycle and returns one result for each item:
// the item sits in an input register, the timer state and compare chain
// update in one pass, and the result is held in an output register. A stalled
// result holds the pipeline, so throughput stays at one item per cycle while
// the output side takes results. Configuration writes are taken in any cycle
// and should only be issued while no item is in flight.
module timer_counter_compare_capture import tcc_pkg::*; #(
	parameter int NUM_CHANNELS = 4,
	parameter int MAX_PRESCALE = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // opcode[3:0], channel[5:4], write_value[37:6], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // read_data[31:0], counter_value[63:32],
	                               // event_flags[67:64], irq[68], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	cfg_t    cfg_q;
	logic    v_s1;
	item_t   item_s1;
	logic    out_v_q;
	result_t out_q;
	result_t res;
	logic    adv;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_COUNTER_MODE: cfg_q.counter_mode   <= cfg_data[0];
				CFG_BIT_MODE:     cfg_q.bit_mode       <= cfg_data[1:0];
				CFG_PRESCALE:     cfg_q.prescale_shift <= cfg_data[3:0];
				CFG_SHORT_MASK:   cfg_q.short_mask     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance stage one when the result register is free or being drained
	assign adv      = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			item_s1 <= s_tdata[37:0];
	end

	tcc_core #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.MAX_PRESCALE (MAX_PRESCALE)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_q <= res;
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {3'd0, out_q};

endmodule

### sv/tcc_core.sv
// Timer state and the combinational update for one item: task, bus access,
// compare chain over all channels, and the result word. Depends on tcc_pkg.
module tcc_core import tcc_pkg::*; #(
	parameter int NUM_CHANNELS = 4,
	parameter int MAX_PRESCALE = 9
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	localparam int PH_W = (MAX_PRESCALE > 0) ? MAX_PRESCALE : 1;

	logic [31:0]             counter_q;
	logic                    running_q;
	logic [PH_W-1:0]         phase_q;
	logic [31:0]             cc_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] ev_q;
	logic [31:0]             ie_q;

	logic [31:0]             cnt_d;
	logic                    run_d;
	logic [PH_W-1:0]         ph_d;
	logic [31:0]             cc_d [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] ev_d;
	logic [31:0]             ie_d;

	// Work out the next state and the result for the item in stage one
	always_comb begin
		logic        chk;
		logic        val_one;
		logic        ch_ok;
		logic [31:0] mask;
		logic [31:0] shorts;
		logic [3:0]  p_eff;
		logic [31:0] rd;
		logic [MAX_CH-1:0] ev_ext;
		logic        irq;

		cnt_d   = counter_q;
		run_d   = running_q;
		ph_d    = phase_q;
		cc_d    = cc_q;
		ev_d    = ev_q;
		ie_d    = ie_q;
		chk     = 1'b1;
		rd      = '0;
		val_one = (item.write_value == 32'd1);
		ch_ok   = (32'(item.channel) < NUM_CHANNELS);
		mask    = width_mask(cfg.bit_mode);
		shorts  = {20'd0, cfg.short_mask};
		p_eff   = (32'(cfg.prescale_shift) > MAX_PRESCALE) ? 4'(MAX_PRESCALE)
			: cfg.prescale_shift;

		unique case (item.opcode)
			OP_TICK: begin
				if (!cfg.counter_mode && running_q) begin
					if (((PH_W+1)'(phase_q) + 1'b1) >= ((PH_W+1)'(1) << p_eff)) begin
						ph_d  = '0;
						cnt_d = (counter_q + 32'd1) & mask;
					end else begin
						ph_d = phase_q + 1'b1;
					end
				end
			end
			OP_START: begin
				if (!running_q && val_one) begin
					run_d = 1'b1;
					ph_d  = '0;
				end
			end
			OP_STOP: begin
				if (running_q && val_one)
					run_d = 1'b0;
			end
			OP_COUNT: begin
				if (val_one && cfg.counter_mode)
					cnt_d = (counter_q + 32'd1) & mask;
			end
			OP_CLEAR: begin
				if (val_one) begin
					cnt_d = '0;
					ph_d  = '0;
				end
			end
			OP_CAPTURE: begin
				for (int i = 0; i < NUM_CHANNELS; i++)
					if (ch_ok && val_one && 32'(item.channel) == i)
						cc_d[i] = counter_q;
			end
			OP_EVENT_WR: begin
				for (int i = 0; i < NUM_CHANNELS; i++)
					if (ch_ok && item.write_value == 32'd0 && 32'(item.channel) == i)
						ev_d[i] = 1'b0;
			end
			OP_INTEN_SET: ie_d = ie_q | item.write_value;
			OP_INTEN_CLR: ie_d = ie_q & ~item.write_value;
			OP_CC_WR: begin
				for (int i = 0; i < NUM_CHANNELS; i++)
					if (ch_ok && 32'(item.channel) == i)
						cc_d[i] = item.write_value & mask;
			end
			OP_CC_RD: begin
				chk = 1'b0;
				for (int i = 0; i < NUM_CHANNELS; i++)
					if (ch_ok && 32'(item.channel) == i)
						rd = cc_q[i];
			end
			OP_INTEN_RD: begin
				chk = 1'b0;
				rd  = ie_q;
			end
			default: chk = 1'b0;
		endcase

		// Compare chain: a clear short is seen by later channels
		if (chk) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (cc_d[i] == cnt_d) begin
					ev_d[i] = 1'b1;
					if (shorts[i])
						cnt_d = '0;
					if (shorts[i+8])
						run_d = 1'b0;
				end
			end
		end

		ev_ext = '0;
		ev_ext[NUM_CHANNELS-1:0] = ev_d;
		irq = 1'b0;
		for (int i = 0; i < NUM_CHANNELS; i++)
			if (ev_d[i] && ie_d[16+i])
				irq = 1'b1;

		result.read_data     = rd;
		result.counter_value = cnt_d;
		result.event_flags   = ev_ext[3:0];
		result.irq           = irq;
	end

	// Commit the state when the item leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			running_q <= 1'b0;
			phase_q   <= '0;
			ev_q      <= '0;
			ie_q      <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++)
				cc_q[i] <= '0;
		end else if (fire) begin
			counter_q <= cnt_d;
			running_q <= run_d;
			phase_q   <= ph_d;
			ev_q      <= ev_d;
			ie_q      <= ie_d;
			cc_q      <= cc_d;
		end
	end

endmodule
